[src/tdcs_pkg.sv]
// Package for the tape deck command sequencer: field widths, sequence codes,
// deck line codes and the timed pattern table.
// No dependencies.
package tdcs_pkg;

  localparam int PIN_W          = 8;
  localparam int LINE_W         = 6;
  localparam int CFG_W          = 11;
  localparam int IDX_W          = 3;
  localparam int MS_W           = 6;
  localparam int TIMEOUT_BITS_D = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1000;

  // command pin positions, all active low
  localparam int PIN_STOP  = 0;
  localparam int PIN_AREW  = 1;
  localparam int PIN_PLAY  = 2;
  localparam int PIN_SKIP  = 3;
  localparam int PIN_APLAY = 4;
  localparam int PIN_FF    = 5;
  localparam int PIN_SRCH  = 6;
  localparam int PIN_REW   = 7;

  localparam logic [LINE_W-1:0] LINE_BLK1 = 6'h02;
  localparam logic [LINE_W-1:0] LINE_HOLD = 6'h10;

  typedef enum logic [6:0] {
    SEQ_IDLE  = 7'b0000001,
    SEQ_STOP  = 7'b0000010,
    SEQ_PLAY  = 7'b0000100,
    SEQ_FF    = 7'b0001000,
    SEQ_REW   = 7'b0010000,
    SEQ_AREW  = 7'b0100000,
    SEQ_APLAY = 7'b1000000
  } seq_t;

  // number of steps in a pattern
  function automatic logic [IDX_W-1:0] pat_len(input seq_t seq);
    case (seq)
      SEQ_STOP:                    pat_len = 3'd1;
      SEQ_PLAY, SEQ_FF, SEQ_APLAY: pat_len = 3'd4;
      SEQ_REW, SEQ_AREW:           pat_len = 3'd5;
      default:                     pat_len = 3'd0;
    endcase
  endfunction

  function automatic logic [LINE_W-1:0] pat_lines(input seq_t seq,
                                                  input logic [IDX_W-1:0] idx);
    logic [LINE_W-1:0] v;
    v = LINE_BLK1;
    case (seq)
      SEQ_STOP: v = 6'h0A;
      SEQ_PLAY, SEQ_APLAY, SEQ_FF: begin
        case (idx)
          3'd0:    v = 6'h02;
          3'd1:    v = 6'h22;
          3'd2:    v = 6'h02;
          3'd3:    v = (seq == SEQ_FF) ? 6'h03 : 6'h06;
          default: v = LINE_BLK1;
        endcase
      end
      SEQ_REW, SEQ_AREW: begin
        case (idx)
          3'd0:    v = 6'h00;
          3'd1:    v = 6'h20;
          3'd2:    v = 6'h00;
          3'd3:    v = 6'h02;
          3'd4:    v = 6'h03;
          default: v = LINE_BLK1;
        endcase
      end
      default: v = LINE_BLK1;
    endcase
    return v;
  endfunction

  function automatic logic [MS_W-1:0] pat_ms(input seq_t seq,
                                             input logic [IDX_W-1:0] idx);
    logic [MS_W-1:0] v;
    v = '0;
    case (seq)
      SEQ_STOP: v = 6'd15;
      SEQ_PLAY, SEQ_APLAY, SEQ_FF: begin
        case (idx)
          3'd0:    v = 6'd5;
          3'd1:    v = 6'd15;
          3'd2:    v = 6'd35;
          3'd3:    v = 6'd15;
          default: v = '0;
        endcase
      end
      SEQ_REW, SEQ_AREW: begin
        case (idx)
          3'd0:    v = 6'd5;
          3'd1:    v = 6'd15;
          3'd2:    v = 6'd15;
          3'd3:    v = 6'd20;
          3'd4:    v = 6'd15;
          default: v = '0;
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  // latch bit cleared when a pattern starts
  function automatic logic [PIN_W-1:0] pat_latch_bit(input seq_t seq);
    logic [PIN_W-1:0] v;
    v = '0;
    case (seq)
      SEQ_STOP:             v[PIN_STOP] = 1'b1;
      SEQ_PLAY, SEQ_APLAY:  v[PIN_PLAY] = 1'b1;
      SEQ_FF:               v[PIN_FF]   = 1'b1;
      SEQ_REW, SEQ_AREW:    v[PIN_REW]  = 1'b1;
      default:              v = '0;
    endcase
    return v;
  endfunction

endpackage

[src/tdcs_if.sv]
// Valid/ready channel interfaces for the sequencer's tick input and result.
// Depends on tdcs_pkg for field widths.
interface tdcs_in_if import tdcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIN_W-1:0]  command_pins;
  logic              counter_edge;
  logic              mode_pin;

  modport source (output valid, command_pins, counter_edge, mode_pin, input ready);
  modport sink   (input valid, command_pins, counter_edge, mode_pin, output ready);
endinterface

interface tdcs_out_if import tdcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] deck_lines;
  logic              tape_end;
  logic              busy_res;

  modport source (output valid, deck_lines, tape_end, busy_res, input ready);
  modport sink   (input valid, deck_lines, tape_end, busy_res, output ready);
endinterface

[src/tape_deck_command_sequencer_core.sv]
// Tape deck command sequencer: command latch, tape-end timeout and timed
// deck line patterns, one result item per tick item.
// Depends on tdcs_pkg and the channel interfaces in tdcs_if.sv.
//
//   channel   dir   handshake            payload
//   in_chan   in    valid/ready          command_pins, counter_edge, mode_pin
//   out_chan  out   valid/ready          deck_lines, tape_end, busy_res
//   cfg       in    cfg_we (no ready)    cfg_wdata = tape_end_timeout_ms
//
// Per item: the state update is one pass of logic from the state
// registers into the state and result registers; a new item is taken in every
// cycle while the result register is empty or being drained.
// A stalled result holds in the output register and blocks input until taken.
// Reset is synchronous (rst_n low); no clearing pass.
module tape_deck_command_sequencer_core
  import tdcs_pkg::*;
#(
  parameter int TIMEOUT_BITS = TIMEOUT_BITS_D
) (
  input  logic             clk,
  input  logic             rst_n,
  tdcs_in_if.sink          in_chan,
  tdcs_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0]        cfg_r;
  logic [PIN_W-1:0]        prev_r, prev_nxt;
  logic [PIN_W-1:0]        latch_r, latch_nxt;
  seq_t                    seq_r, seq_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [MS_W-1:0]         rem_r, rem_nxt;
  logic [LINE_W-1:0]       line_r, line_nxt;
  logic                    play_r, play_nxt;
  logic                    rew_r, rew_nxt;
  logic [TIMEOUT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    tact_r, tact_nxt;
  logic                    tend_r, tend_nxt;
  logic                    svc_r, svc_nxt;
  logic [1:0]              auto_r, auto_nxt;

  logic                    out_valid_r;
  logic [LINE_W-1:0]       out_lines_r;
  logic                    out_tend_r;
  logic                    out_busy_r;

  logic                    accept;
  logic [15:0]             cfg_ext;
  logic [TIMEOUT_BITS-1:0] limit;
  logic [TIMEOUT_BITS:0]   cnt_inc;
  logic [PIN_W-1:0]        pins;
  seq_t                    start_seq;
  logic                    start_en;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign pins          = in_chan.command_pins;

  assign cfg_ext = 16'(cfg_r);
  assign limit   = cfg_ext[TIMEOUT_BITS-1:0];
  assign cnt_inc = {1'b0, cnt_r} + {{TIMEOUT_BITS{1'b0}}, 1'b1};

  always_comb begin
    prev_nxt  = pins;
    latch_nxt = latch_r;
    seq_nxt   = seq_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    line_nxt  = line_r;
    play_nxt  = play_r;
    rew_nxt   = rew_r;
    cnt_nxt   = cnt_r;
    tact_nxt  = tact_r;
    tend_nxt  = tend_r;
    svc_nxt   = svc_r;
    auto_nxt  = auto_r;
    start_seq = SEQ_IDLE;
    start_en  = 1'b0;

    // latch every low pin on any change, the skipped pin excluded
    if (((pins ^ prev_r) & 8'hF7) != 8'h00) begin
      latch_nxt = latch_nxt | ~(pins | 8'h08);
    end

    if (in_chan.counter_edge) begin
      tact_nxt = 1'b1;
      cnt_nxt  = '0;
      tend_nxt = 1'b0;
    end else if (tact_r) begin
      if (cnt_inc >= {1'b0, limit}) begin
        tact_nxt = 1'b0;
        cnt_nxt  = '0;
        tend_nxt = 1'b1;
        if (play_r && !pins[PIN_AREW]) auto_nxt[0] = 1'b1;
        if (rew_r && !pins[PIN_APLAY]) auto_nxt[1] = 1'b1;
      end else begin
        cnt_nxt = cnt_inc[TIMEOUT_BITS-1:0];
      end
    end

    if (!svc_r && !in_chan.mode_pin) begin
      svc_nxt  = 1'b1;
      line_nxt = line_nxt | LINE_HOLD;
    end

    // advance the running pattern
    if (seq_r != SEQ_IDLE) begin
      if (rem_nxt != '0) rem_nxt = rem_nxt - 1'b1;
      if (rem_nxt == '0) begin
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt >= pat_len(seq_r)) begin
          line_nxt = LINE_BLK1;
          play_nxt = (seq_r == SEQ_PLAY) || (seq_r == SEQ_APLAY);
          rew_nxt  = (seq_r == SEQ_REW) || (seq_r == SEQ_AREW);
          if (seq_r == SEQ_AREW && !pins[PIN_APLAY]) auto_nxt[1] = 1'b1;
          seq_nxt = SEQ_IDLE;
          idx_nxt = '0;
        end else begin
          rem_nxt  = pat_ms(seq_r, idx_nxt);
          line_nxt = pat_lines(seq_r, idx_nxt);
        end
      end
    end

    // pick the next pattern: auto sequences first, then latched commands
    if (seq_nxt == SEQ_IDLE) begin
      if (auto_nxt[0]) begin
        auto_nxt[0] = 1'b0;
        start_seq   = SEQ_AREW;
        start_en    = 1'b1;
      end else if (auto_nxt[1]) begin
        auto_nxt[1] = 1'b0;
        start_seq   = SEQ_APLAY;
        start_en    = 1'b1;
      end else if (svc_nxt) begin
        start_en = 1'b1;
        if (latch_nxt[PIN_STOP])      start_seq = SEQ_STOP;
        else if (latch_nxt[PIN_PLAY]) start_seq = SEQ_PLAY;
        else if (latch_nxt[PIN_FF])   start_seq = SEQ_FF;
        else if (latch_nxt[PIN_REW])  start_seq = SEQ_REW;
        else begin
          start_en = 1'b0;
          // search only drops its latch bit
          latch_nxt[PIN_SRCH] = 1'b0;
        end
      end
    end

    if (start_en) begin
      latch_nxt = latch_nxt & ~pat_latch_bit(start_seq);
      seq_nxt   = start_seq;
      idx_nxt   = '0;
      rem_nxt   = pat_ms(start_seq, '0);
      line_nxt  = pat_lines(start_seq, '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '1;
      latch_r <= '0;
      seq_r   <= SEQ_IDLE;
      idx_r   <= '0;
      rem_r   <= '0;
      line_r  <= LINE_BLK1;
      play_r  <= 1'b0;
      rew_r   <= 1'b0;
      cnt_r   <= '0;
      tact_r  <= 1'b0;
      tend_r  <= 1'b1;
      svc_r   <= 1'b0;
      auto_r  <= '0;
    end else if (accept) begin
      prev_r  <= prev_nxt;
      latch_r <= latch_nxt;
      seq_r   <= seq_nxt;
      idx_r   <= idx_nxt;
      rem_r   <= rem_nxt;
      line_r  <= line_nxt;
      play_r  <= play_nxt;
      rew_r   <= rew_nxt;
      cnt_r   <= cnt_nxt;
      tact_r  <= tact_nxt;
      tend_r  <= tend_nxt;
      svc_r   <= svc_nxt;
      auto_r  <= auto_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with the new state on every accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      out_lines_r <= line_nxt;
      out_tend_r  <= tend_nxt;
      out_busy_r  <= (seq_nxt != SEQ_IDLE);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.deck_lines = out_lines_r;
  assign out_chan.tape_end   = out_tend_r;
  assign out_chan.busy_res   = out_busy_r;

endmodule
